// ----- rtl/dspa_pkg.sv -----
// Shared types and constants for the DSP-ADPCM channel decoder.
// No dependencies; other RTL but dspa_fifo uses scoped names, the dv files import it.
`default_nettype none

package dspa_pkg;

  // Sample counter width default (top-level parameter COUNT_BITS)
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned SEL_W      = 3;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CNT_IN_W   = 16;
  localparam int unsigned FRAME_POS_W = 3;

  // Coefficient register file
  localparam int unsigned NUM_PAIRS  = 8;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned COEF_W     = 16;

  // Predictor arithmetic
  localparam int unsigned SUM_W      = 36;
  localparam int unsigned FRAC_BITS  = 11;
  localparam int          ROUND_BIAS = 1024;
  localparam int          SAMPLE_MIN = -32768;
  localparam int          SAMPLE_MAX = 32767;

  // Input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Queue depths
  localparam int unsigned OP_DEPTH  = 2;
  localparam int unsigned RES_DEPTH = 2;

  typedef enum logic {
    OP_START,
    OP_DATA
  } op_e;

  // One decoded work item handed from front to back
  typedef struct packed {
    op_e                        op;
    logic signed [SAMPLE_W-1:0] hist_one;
    logic signed [SAMPLE_W-1:0] hist_two;
    logic [NIB_W-1:0]           nib_hi;
    logic [NIB_W-1:0]           nib_lo;
    logic [SHIFT_W-1:0]         shift;
    logic [SEL_W-1:0]           sel;
    logic                       two;   // both nibbles carry samples
    logic                       last;  // final sample of this op ends the record
  } op_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/dspa_fifo.sv -----
// Small synchronous queue, used between front and back and on the result side.
// No dependencies.
`default_nettype none

module dspa_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             rd_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o,
  output logic                  full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dspa_front.sv -----
// Front end: accepts input beats, tracks frame position, header and count.
// Depends on dspa_pkg; emits one op_t per start item and per sample byte.
`default_nettype none

module dspa_front #(
  parameter int unsigned COUNT_BITS = dspa_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  take_i,
  input  wire logic                                  kind_i,
  input  wire logic        [dspa_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic signed [dspa_pkg::SAMPLE_W-1:0]  first_history_i,
  input  wire logic signed [dspa_pkg::SAMPLE_W-1:0]  second_history_i,
  input  wire logic        [dspa_pkg::CNT_IN_W-1:0]  sample_count_i,
  output logic                                       op_wr_o,
  output dspa_pkg::op_t                              op_o
);

  localparam int unsigned WideW = 33;

  logic [COUNT_BITS-1:0]                left_q, left_d;
  logic [dspa_pkg::FRAME_POS_W-1:0]     pos_q, pos_d;
  logic [dspa_pkg::SHIFT_W-1:0]         shift_q, shift_d;
  logic [dspa_pkg::SEL_W-1:0]           sel_q, sel_d;
  logic [WideW-1:0]                     cnt_wide, cnt_max, cnt_sat;
  logic                                 is_start, has_left, one_left;

  assign is_start = (kind_i == dspa_pkg::KIND_START);
  assign has_left = (left_q != '0);
  assign one_left = (left_q == COUNT_BITS'(1));

  // Saturate the record count to the counter width
  always_comb begin
    cnt_wide = WideW'(sample_count_i);
    cnt_max  = (WideW'(1) << COUNT_BITS) - WideW'(1);
    cnt_sat  = (cnt_wide > cnt_max) ? cnt_max : cnt_wide;
  end

  always_comb begin
    left_d  = left_q;
    pos_d   = pos_q;
    shift_d = shift_q;
    sel_d   = sel_q;
    op_wr_o = 1'b0;

    op_o.op       = is_start ? dspa_pkg::OP_START : dspa_pkg::OP_DATA;
    op_o.hist_one = first_history_i;
    op_o.hist_two = second_history_i;
    op_o.nib_hi   = data_byte_i[7:4];
    op_o.nib_lo   = data_byte_i[3:0];
    op_o.shift    = shift_q;
    op_o.sel      = sel_q;
    op_o.two      = !one_left;
    op_o.last     = (left_q <= COUNT_BITS'(2));

    if (take_i) begin
      if (is_start) begin
        left_d  = cnt_sat[COUNT_BITS-1:0];
        pos_d   = '0;
        shift_d = '0;
        sel_d   = '0;
        op_wr_o = 1'b1;
      end else if (has_left) begin
        if (pos_q == '0) begin
          // Frame header: latch scale and predictor pair, bit 7 unused
          shift_d = data_byte_i[3:0];
          sel_d   = data_byte_i[6:4];
          pos_d   = dspa_pkg::FRAME_POS_W'(1);
        end else begin
          pos_d   = pos_q + dspa_pkg::FRAME_POS_W'(1);
          left_d  = left_q - (one_left ? COUNT_BITS'(1) : COUNT_BITS'(2));
          op_wr_o = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      pos_q   <= '0;
      shift_q <= '0;
      sel_q   <= '0;
    end else begin
      left_q  <= left_d;
      pos_q   <= pos_d;
      shift_q <= shift_d;
      sel_q   <= sel_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dspa_back.sv -----
// Back end: coefficient registers, history and the predictor datapath.
// Depends on dspa_pkg; high nibble then low nibble, one sample per cycle unless the result queue is full.
`default_nettype none

module dspa_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [dspa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [dspa_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                               op_valid_i,
  input  dspa_pkg::op_t                           op_i,
  output logic                                    op_rd_o,
  input  wire logic                               res_full_i,
  output logic                                    res_wr_o,
  output dspa_pkg::res_t                          res_o
);

  localparam int unsigned SW = dspa_pkg::SUM_W;

  logic [dspa_pkg::CFG_DATA_W-1:0]        coef_q [dspa_pkg::NUM_PAIRS];
  logic signed [dspa_pkg::SAMPLE_W-1:0]   hist1_q, hist2_q;
  logic                                   phase_q;

  logic [dspa_pkg::CFG_DATA_W-1:0]        pair;
  logic signed [dspa_pkg::COEF_W-1:0]     c0, c1;
  logic signed [2*dspa_pkg::COEF_W-1:0]   prod0, prod1;
  logic signed [dspa_pkg::NIB_W-1:0]      nib;
  logic signed [SW-1:0]                   scaled, sum, q;
  logic signed [dspa_pkg::SAMPLE_W-1:0]   smp;
  logic                                   is_data, final_nib, do_start, do_data;

  always_comb begin
    pair   = coef_q[op_i.sel];
    c0     = pair[31:16];
    c1     = pair[15:0];
    nib    = phase_q ? op_i.nib_lo : op_i.nib_hi;
    prod0  = c0 * hist1_q;
    prod1  = c1 * hist2_q;
    scaled = SW'(nib) <<< op_i.shift;
    sum    = (scaled <<< dspa_pkg::FRAC_BITS) + SW'(dspa_pkg::ROUND_BIAS)
             + SW'(prod0) + SW'(prod1);
    q      = sum >>> dspa_pkg::FRAC_BITS;
    if (q < SW'(dspa_pkg::SAMPLE_MIN)) begin
      smp = dspa_pkg::SAMPLE_W'(dspa_pkg::SAMPLE_MIN);
    end else if (q > SW'(dspa_pkg::SAMPLE_MAX)) begin
      smp = dspa_pkg::SAMPLE_W'(dspa_pkg::SAMPLE_MAX);
    end else begin
      smp = q[dspa_pkg::SAMPLE_W-1:0];
    end
  end

  assign is_data   = (op_i.op == dspa_pkg::OP_DATA);
  assign final_nib = phase_q || !op_i.two;
  assign do_start  = op_valid_i && !is_data;
  assign do_data   = op_valid_i && is_data && !res_full_i;
  assign op_rd_o   = do_start || (do_data && final_nib);
  assign res_wr_o  = do_data;

  always_comb begin
    res_o.sample = smp;
    res_o.last   = final_nib && op_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist1_q <= '0;
      hist2_q <= '0;
      phase_q <= 1'b0;
    end else if (do_start) begin
      hist1_q <= op_i.hist_one;
      hist2_q <= op_i.hist_two;
      phase_q <= 1'b0;
    end else if (do_data) begin
      hist2_q <= hist1_q;
      hist1_q <= smp;
      phase_q <= !final_nib;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dspa_pkg::NUM_PAIRS; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < dspa_pkg::CFG_IDX_W'(dspa_pkg::NUM_PAIRS))) begin
      coef_q[cfg_idx_i[dspa_pkg::SEL_W-1:0]] <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/dsp_adpcm_channel_decoder.sv -----
// Top level of the single-channel DSP-ADPCM decoder.
// Depends on dspa_pkg, dspa_front, dspa_fifo and dspa_back.
//
// Usage:
//   Input channel (push/full): a beat is taken when push is high and full low.
//   A start beat (kind_i = 0) loads both history samples and the sample count.
//   Data beats (kind_i = 1) follow in 8-byte frames: a header byte (scale in
//   bits 3:0, predictor pair in bits 6:4) then seven bytes of two nibbles.
//   Data beats with no samples left are dropped.
//   Result channel (empty/pop): the oldest sample sits on sample_o/last_o
//   while empty is low; last_o marks the final sample of the record.
//   Coefficient pairs 0..7 are written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
//   the user writes them only while the decoder is idle, which the block does
//   not enforce. Higher indexes are ignored.
// Timing:
//   A byte's samples pass the op queue and the result queue before they show.
//   The back end produces one sample per cycle while the result queue has room,
//   headers skip it. The history recurrence through the multiply-add bounds this rate.
// Reset clears the counters, history, coefficients and both queues. When the
//   receiver stalls, results collect in the result queue, then the op queue
//   fills and full rises; nothing is lost.
`default_nettype none

module dsp_adpcm_channel_decoder #(
  parameter int unsigned COUNT_BITS = dspa_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  push,
  output logic                                       full,
  input  wire logic                                  kind_i,
  input  wire logic        [dspa_pkg::BYTE_W-1:0]    data_byte_i,
  input  wire logic signed [dspa_pkg::SAMPLE_W-1:0]  first_history_i,
  input  wire logic signed [dspa_pkg::SAMPLE_W-1:0]  second_history_i,
  input  wire logic        [dspa_pkg::CNT_IN_W-1:0]  sample_count_i,
  output logic                                       empty,
  input  wire logic                                  pop,
  output logic signed      [dspa_pkg::SAMPLE_W-1:0]  sample_o,
  output logic                                       last_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic        [dspa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic        [dspa_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned OpW  = $bits(dspa_pkg::op_t);
  localparam int unsigned ResW = $bits(dspa_pkg::res_t);

  logic            take;
  logic            op_wr, op_rd, op_empty, op_full;
  dspa_pkg::op_t   op_in, op_head;
  logic [OpW-1:0]  op_head_raw;
  logic            res_wr, res_full;
  dspa_pkg::res_t  res_in, res_head;
  logic [ResW-1:0] res_head_raw;

  // Hold input while the op queue has no room
  assign full = op_full;
  assign take = push && !op_full;

  dspa_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .take_i           (take),
    .kind_i           (kind_i),
    .data_byte_i      (data_byte_i),
    .first_history_i  (first_history_i),
    .second_history_i (second_history_i),
    .sample_count_i   (sample_count_i),
    .op_wr_o          (op_wr),
    .op_o             (op_in)
  );

  dspa_fifo #(
    .WIDTH (OpW),
    .DEPTH (dspa_pkg::OP_DEPTH)
  ) u_op_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (op_wr),
    .wdata_i (op_in),
    .rd_i    (op_rd),
    .rdata_o (op_head_raw),
    .empty_o (op_empty),
    .full_o  (op_full)
  );

  assign op_head = dspa_pkg::op_t'(op_head_raw);

  dspa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_valid_i  (!op_empty),
    .op_i        (op_head),
    .op_rd_o     (op_rd),
    .res_full_i  (res_full),
    .res_wr_o    (res_wr),
    .res_o       (res_in)
  );

  // Result queue parts the datapath from a stalling receiver
  dspa_fifo #(
    .WIDTH (ResW),
    .DEPTH (dspa_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_wr),
    .wdata_i (res_in),
    .rd_i    (pop),
    .rdata_o (res_head_raw),
    .empty_o (empty),
    .full_o  (res_full)
  );

  assign res_head = dspa_pkg::res_t'(res_head_raw);
  assign sample_o = res_head.sample;
  assign last_o   = res_head.last;

endmodule

`default_nettype wire

// ----- rtl/dspa_checker.sv -----
// Port-level checks for the DSP-ADPCM decoder, bound to the top level.
// Depends on dspa_pkg and dsp_adpcm_channel_decoder.
`default_nettype none

module dspa_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 push,
  input wire logic                                 full,
  input wire logic                                 empty,
  input wire logic                                 pop,
  input wire logic signed [dspa_pkg::SAMPLE_W-1:0] sample_o,
  input wire logic                                 last_o
);

  // Queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty && !full)
    else $error("result queue not empty after reset");

  // Full only rises on an accepted input beat
  a_full_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full && !push |=> !full)
    else $error("full rose without an input beat");

  // A waiting result holds until popped
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(sample_o) && $stable(last_o))
    else $error("waiting result changed or vanished");

endmodule

bind dsp_adpcm_channel_decoder dspa_checker u_dspa_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .sample_o (sample_o),
  .last_o   (last_o)
);

`default_nettype wire

// ----- dv/dspa_decode_checker.sv -----
// Checker for the DSP-ADPCM channel decoder: tracks coefficient writes and input
// beats, predicts every decoded sample, and compares it with each result beat.
// Depends on dspa_pkg for field widths, item kinds and the result struct.
module dspa_decode_checker (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   push,
  input  wire logic                                   full,
  input  wire logic                                   kind_i,
  input  wire logic        [dspa_pkg::BYTE_W-1:0]     data_byte_i,
  input  wire logic signed [dspa_pkg::SAMPLE_W-1:0]   first_history_i,
  input  wire logic signed [dspa_pkg::SAMPLE_W-1:0]   second_history_i,
  input  wire logic        [dspa_pkg::CNT_IN_W-1:0]   sample_count_i,
  input  wire logic                                   empty,
  input  wire logic                                   pop,
  input  wire logic signed [dspa_pkg::SAMPLE_W-1:0]   sample_o,
  input  wire logic                                   last_o,
  input  wire logic                                   cfg_we_i,
  input  wire logic        [dspa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic        [dspa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                                          pending_o,
  output int                                          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import dspa_pkg::*;

  logic [CFG_DATA_W-1:0]      coef_pairs [NUM_PAIRS];
  logic signed [SAMPLE_W-1:0] hist_one;
  logic signed [SAMPLE_W-1:0] hist_two;
  logic [SHIFT_W-1:0]         scale;
  logic [SEL_W-1:0]           pair_sel;
  logic [FRAME_POS_W-1:0]     frame_pos;
  logic [CNT_IN_W-1:0]        samples_left;
  res_t                       expected_samples [$];
  res_t                       head;
  int                         fail_total;

  // One predictor step: scaled nibble plus weighted history, rounded and clipped.
  function automatic logic signed [SAMPLE_W-1:0] decode_nibble(
    input logic [NIB_W-1:0]         nib,
    input logic [SHIFT_W-1:0]       shift,
    input logic [CFG_DATA_W-1:0]    pair,
    input logic signed [SAMPLE_W-1:0] h1,
    input logic signed [SAMPLE_W-1:0] h2
  );
    longint c0;
    longint c1;
    longint acc;
    c0  = longint'($signed(pair[31:16]));
    c1  = longint'($signed(pair[15:0]));
    acc = longint'($signed(nib)) * (longint'(1) << shift) * 2048 + ROUND_BIAS
        + c0 * longint'(h1) + c1 * longint'(h2);
    acc = acc >>> FRAC_BITS;
    if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
    if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
    return acc[SAMPLE_W-1:0];
  endfunction

  task automatic emit_sample(input logic [NIB_W-1:0] nib);
    logic signed [SAMPLE_W-1:0] s;
    res_t item;
    s = decode_nibble(nib, scale, coef_pairs[pair_sel], hist_one, hist_two);
    hist_two     = hist_one;
    hist_one     = s;
    samples_left = samples_left - 1'b1;
    item.sample  = s;
    item.last    = (samples_left == '0);
    expected_samples.push_back(item);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (coef_pairs[i]) coef_pairs[i] = '0;
      hist_one     = '0;
      hist_two     = '0;
      scale        = '0;
      pair_sel     = '0;
      frame_pos    = '0;
      samples_left = '0;
      expected_samples.delete();
      fail_total   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i && cfg_idx_i < NUM_PAIRS) coef_pairs[cfg_idx_i[SEL_W-1:0]] = cfg_wdata_i;

      // Compare first: a beat popped now can only come from an earlier input.
      if (pop && !empty) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result beat: sample %0d, last %0b", sample_o, last_o);
          fail_total++;
        end else begin
          head = expected_samples.pop_front();
          if (sample_o !== head.sample) begin
            $error("sample: expected %0d, actual %0d", head.sample, sample_o);
            fail_total++;
          end
          if (last_o !== head.last) begin
            $error("last: expected %0b, actual %0b", head.last, last_o);
            fail_total++;
          end
        end
      end

      if (push && !full) begin
        if (kind_i == KIND_START) begin
          hist_one     = first_history_i;
          hist_two     = second_history_i;
          samples_left = sample_count_i;
          frame_pos    = '0;
          scale        = '0;
          pair_sel     = '0;
        end else if (samples_left != '0) begin
          if (frame_pos == '0) begin
            scale     = data_byte_i[3:0];
            pair_sel  = data_byte_i[6:4];
            frame_pos = FRAME_POS_W'(1);
          end else begin
            frame_pos = frame_pos + 1'b1;
            emit_sample(data_byte_i[7:4]);
            if (samples_left != '0) emit_sample(data_byte_i[3:0]);
          end
        end
      end

      pending_o    <= expected_samples.size();
      fail_count_o <= fail_total;
    end
  end

endmodule

// ----- dv/dsp_adpcm_channel_decoder_test.sv -----
// Top of the DSP-ADPCM channel decoder testbench: clock, reset, stimulus and verdict.
// Depends on dspa_pkg, the decoder RTL and dspa_decode_checker.
module dsp_adpcm_channel_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dspa_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int DRAIN_CYCLES   = 16;    // covers a header or dropped byte still in flight
  localparam int HOLD_CYCLES    = 500;   // long receiver hold-off for the backpressure pass
  localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before the run is declared hung
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_ITEMS    = 135;   // record beats per phase, about 1100 in total

  // Flavors of coefficient sets loaded between phases
  typedef enum int {
    COEF_EDGE,   // halves drawn from the signed extremes, zero and minus one
    COEF_AUDIO,  // realistic predictor weights
    COEF_WILD    // any 32-bit pattern
  } coef_style_e;

  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic                    push             = 1'b0;
  logic                    kind_i           = KIND_START;
  logic [BYTE_W-1:0]       data_byte_i      = '0;
  logic signed [SAMPLE_W-1:0] first_history_i  = '0;
  logic signed [SAMPLE_W-1:0] second_history_i = '0;
  logic [CNT_IN_W-1:0]     sample_count_i   = '0;
  logic                    pop              = 1'b0;
  logic                    cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i        = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i      = '0;
  logic                    full;
  logic                    empty;
  logic signed [SAMPLE_W-1:0] sample_o;
  logic                    last_o;

  int pending;
  int fail_count;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int record_items   = 0;
  int quiet_cycles   = 0;
  bit hold_req       = 1'b0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  dsp_adpcm_channel_decoder u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .kind_i           (kind_i),
    .data_byte_i      (data_byte_i),
    .first_history_i  (first_history_i),
    .second_history_i (second_history_i),
    .sample_count_i   (sample_count_i),
    .empty            (empty),
    .pop              (pop),
    .sample_o         (sample_o),
    .last_o           (last_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  dspa_decode_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .kind_i           (kind_i),
    .data_byte_i      (data_byte_i),
    .first_history_i  (first_history_i),
    .second_history_i (second_history_i),
    .sample_count_i   (sample_count_i),
    .empty            (empty),
    .pop              (pop),
    .sample_o         (sample_o),
    .last_o           (last_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  // Offer one input beat and hold it until the decoder takes it. Push stays high
  // on return so back-to-back beats need no gap; the next call drops it if it idles.
  task automatic send_beat(
    input logic                      kind,
    input logic [BYTE_W-1:0]         byte_val,
    input logic signed [SAMPLE_W-1:0] h1,
    input logic signed [SAMPLE_W-1:0] h2,
    input logic [CNT_IN_W-1:0]       cnt
  );
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push             <= 1'b1;
    kind_i           <= kind;
    data_byte_i      <= byte_val;
    first_history_i  <= h1;
    second_history_i <= h2;
    sample_count_i   <= cnt;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Unused fields carry junk so the decoder is seen to ignore them.
  task automatic send_start(
    input logic signed [SAMPLE_W-1:0] h1,
    input logic signed [SAMPLE_W-1:0] h2,
    input logic [CNT_IN_W-1:0]       cnt
  );
    send_beat(KIND_START, BYTE_W'($urandom), h1, h2, cnt);
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] byte_val);
    send_beat(KIND_DATA, byte_val, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
              CNT_IN_W'($urandom));
  endtask

  // One record: start beat, then 8-byte frames of header plus sample bytes with
  // random content. A broken record may end early and is trailed by up to three stray bytes.
  task automatic send_record(input int num_samples, input bit broken);
    int left;
    int cut;
    int pos;
    left = num_samples;
    cut  = broken ? $urandom_range(1, 20) : num_samples + 8;
    pos  = 0;
    send_start(SAMPLE_W'($urandom), SAMPLE_W'($urandom), CNT_IN_W'(num_samples));
    record_items++;
    while (left > 0 && pos < cut) begin
      send_byte(BYTE_W'($urandom));
      if (pos % 8 != 0) left -= 2;
      pos++;
      record_items++;
    end
    if (broken) begin
      repeat ($urandom_range(3)) send_byte(BYTE_W'($urandom));
      // a start with any 16-bit count, left dangling until the next record
      if ($urandom_range(1)) send_start(SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                                        CNT_IN_W'($urandom));
    end
  endtask

  // Drop push, wait out every expected sample, then let stray work settle.
  task automatic wait_quiet();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Load all eight pairs, then one write to an unmapped index that must be dropped.
  task automatic write_pairs(input coef_style_e style);
    logic [COEF_W-1:0] edges [4];
    edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    for (int i = 0; i < NUM_PAIRS; i++) begin
      cfg_we_i  <= 1'b1;
      cfg_idx_i <= CFG_IDX_W'(i);
      case (style)
        COEF_EDGE:  cfg_wdata_i <= {edges[$urandom_range(3)], edges[$urandom_range(3)]};
        COEF_AUDIO: cfg_wdata_i <= {COEF_W'($urandom_range(4095)),
                                    COEF_W'($urandom_range(4095) - 2048)};
        default:    cfg_wdata_i <= $urandom;
      endcase
      @(posedge clk_i);
    end
    cfg_idx_i   <= CFG_IDX_W'(NUM_PAIRS + $urandom_range(NUM_PAIRS - 1));
    cfg_wdata_i <= $urandom;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Receiver: pop at random, or hold off for a long stretch when asked so the
  // result and op queues fill and full rises against a busy sender.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles in which no beat moves on either side and no pair is written.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("dsp_adpcm_channel_decoder_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int len;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_pairs(COEF_EDGE);

    // Directed part, no idling on either side.
    send_byte(8'h5A);                         // data before any start: dropped
    send_start(16'sh7FFF, -16'sh8000, 16'd5); // extreme histories
    send_byte(8'h8F);                         // header with bit 7 set, max shift, pair 0
    send_byte(8'h7F);                         // extreme nibbles both ways
    send_byte(8'h80);
    send_byte(8'hF8);                         // count ends on the high nibble
    send_byte(8'h12);                         // count used up: dropped
    send_start(16'sh0000, 16'sh0000, 16'd0);  // empty record
    send_byte(8'h34);                         // dropped
    send_start(-16'sh8000, 16'sh7FFF, 16'd14);// exactly one full frame
    send_byte(8'h70);                         // pair 7, no shift
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h88);
    send_byte(8'h77);
    send_byte(8'h0F);
    send_byte(8'hF0);
    send_byte(8'h81);
    send_start(-16'sh0001, 16'sh5555, 16'hFFFF); // largest count, cut short below
    send_byte(8'hC4);
    send_byte(8'hA5);
    send_start(16'sh2AAA, -16'sh2AAB, 16'd3);    // restart mid-record
    send_byte(8'h3C);
    send_byte(8'h9A);
    send_byte(8'hBC);
    wait_quiet();

    // Backpressure: long receiver hold while the sender keeps offering beats.
    hold_req = 1'b1;
    send_record(200, 1'b0);

    // Random phases, each with its own coefficient set and idle pattern.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_quiet();
      write_pairs(coef_style_e'(phase % 3));
      case (phase % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      while (record_items < (phase + 1) * PHASE_ITEMS + 24) begin
        // mostly short records, now and then a long one spanning many frames
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
        send_record(len, $urandom_range(4) == 0);
      end
    end

    wait_quiet();
    if (fail_count == 0) $display("dsp_adpcm_channel_decoder_test: PASS");
    else $display("dsp_adpcm_channel_decoder_test: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dspa_pkg.sv
rtl/dspa_fifo.sv
rtl/dspa_front.sv
rtl/dspa_back.sv
rtl/dsp_adpcm_channel_decoder.sv
rtl/dspa_checker.sv
dv/dspa_decode_checker.sv
dv/dsp_adpcm_channel_decoder_test.sv
